// ===== sv/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types, codes and sizes of the edge coverage tracker.
// ----------------------------------------------------------------------------
package ect_pkg;

    // map sizes are powers of two, given by their address widths
    localparam int EDGE_MAP_AW      = 16;
    localparam int PATH_MAP_AW      = 16;
    localparam int EDGE_MAP_ENTRIES = 1 << EDGE_MAP_AW;
    localparam int PATH_MAP_ENTRIES = 1 << PATH_MAP_AW;

    localparam int SWEEP_ENTRIES =
        (EDGE_MAP_ENTRIES > PATH_MAP_ENTRIES) ? EDGE_MAP_ENTRIES : PATH_MAP_ENTRIES;
    localparam int SWEEP_AW = $clog2(SWEEP_ENTRIES);

    // history keeps one bit above the slot bits, since it is shifted right by one
    localparam int PREV_W = EDGE_MAP_AW + 1;

    localparam int          COUNT_W     = 8;
    localparam logic [7:0]  COUNTER_MAX = 8'd255;
    localparam int          UNIQUE_W    = 17;
    localparam logic [16:0] UNIQUE_MAX  = 17'h1FFFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_TRACE  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_TRACE_EN  = 2'd0,
        CFG_PATH_EN   = 2'd1,
        CFG_WIN_START = 2'd2,
        CFG_WIN_END   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_TRACE,
        K_CLEAR,
        K_READ,
        K_DROP
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [EDGE_MAP_AW-1:0] edge_idx;
        logic                   path_upd;
        logic [PATH_MAP_AW-1:0] path_idx;
        logic [15:0]            slot;
        logic                   rd_ok;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_ACCESS,
        S_CLEAR
    } t_state;

endpackage

// ===== sv/ect_ram.sv =====
// ----------------------------------------------------------------------------
// ect_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ect_front.sv =====
// ----------------------------------------------------------------------------
// ect_front
// Accepts trace, clear and read items, applies the address window, forms the
// edge slot and the rolling path hash, and queues one command per item.
// ----------------------------------------------------------------------------
module ect_front import ect_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_push,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_program_counter,
    input  logic [15:0] i_map_index,
    input  logic        i_q_full,
    input  logic        i_hold,
    output logic        o_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic              r_trace_en;
    logic              r_path_en;
    logic [63:0]       r_win_start;
    logic [63:0]       r_win_end;
    logic [PREV_W-1:0] r_prev;
    logic [63:0]       r_hash;

    logic                   accept;
    logic                   in_win;
    logic                   above_start;
    logic [63:0]            loc;
    logic [EDGE_MAP_AW-1:0] edge_idx;
    logic [63:0]            hash_next;
    logic                   take_trace;
    t_op                    op;
    t_cmd                   cmd;

    assign o_full = i_q_full || i_hold;
    assign accept = i_push && !o_full;
    assign op     = t_op'(i_operation);

    always_comb begin
        in_win = (r_win_start == '0) || (r_win_end == '0) ||
                 ((i_program_counter >= r_win_start) && (i_program_counter <= r_win_end));
        above_start = (r_win_start != '0) && (i_program_counter >= r_win_start);
        loc         = above_start ? (i_program_counter - r_win_start) : i_program_counter;
        edge_idx    = r_prev[PREV_W-1:1] ^ loc[EDGE_MAP_AW-1:0];
        hash_next   = {r_hash[62:0], r_hash[63]} ^ loc;
        take_trace  = (op == OP_TRACE) && r_trace_en && in_win;
    end

    always_comb begin
        cmd.kind     = K_DROP;
        cmd.edge_idx = edge_idx;
        cmd.path_upd = 1'b0;
        cmd.path_idx = hash_next[PATH_MAP_AW-1:0];
        cmd.slot     = '0;
        cmd.rd_ok    = 1'b0;
        case (op)
            OP_TRACE: begin
                if (take_trace) begin
                    cmd.kind     = K_TRACE;
                    cmd.path_upd = r_path_en;
                    cmd.slot     = 16'(edge_idx);
                end
            end
            OP_CLEAR: begin
                cmd.kind = K_CLEAR;
            end
            OP_READ: begin
                cmd.kind     = K_READ;
                cmd.edge_idx = EDGE_MAP_AW'(i_map_index);
                cmd.slot     = i_map_index;
                cmd.rd_ok    = (32'(i_map_index) < 32'(EDGE_MAP_ENTRIES));
            end
            default: begin
                cmd.kind = K_DROP;
            end
        endcase
    end

    assign o_q_push = accept;
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_en  <= 1'b0;
            r_path_en   <= 1'b0;
            r_win_start <= '0;
            r_win_end   <= '0;
            r_prev      <= '0;
            r_hash      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TRACE_EN:  r_trace_en  <= i_cfg_data[0];
                    CFG_PATH_EN:   r_path_en   <= i_cfg_data[0];
                    CFG_WIN_START: r_win_start <= i_cfg_data;
                    CFG_WIN_END:   r_win_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (take_trace) begin
                    r_prev <= loc[PREV_W-1:0];
                    if (r_path_en) begin
                        r_hash <= hash_next;
                    end
                end else if (op == OP_CLEAR) begin
                    r_prev <= '0;
                    r_hash <= '0;
                end
            end
        end
    end

endmodule

// ===== sv/ect_queue.sv =====
// ----------------------------------------------------------------------------
// ect_queue
// Short command queue between the classifying front and the map back end.
// ----------------------------------------------------------------------------
module ect_queue import ect_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_AW-1:0]    r_wp;
    logic [Q_AW-1:0]    r_rp;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rp];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/ect_back.sv =====
// ----------------------------------------------------------------------------
// ect_back
// Carries out queued commands on the edge and path maps: read-modify-write of
// the saturating counters, clearing sweeps, counts and the result register.
// ----------------------------------------------------------------------------
module ect_back import ect_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_head       i_head,
    output logic          o_q_pop,
    output logic          o_hold,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_accepted,
    output logic          o_new_edge,
    output logic [15:0]   o_edge_slot,
    output logic [7:0]    o_counter_value,
    output logic [16:0]   o_distinct_edges,
    output logic [63:0]   o_edge_total
);

    t_state                r_state;
    t_state                n_state;
    logic [SWEEP_AW-1:0]   r_sweep;
    logic [SWEEP_AW-1:0]   n_sweep;
    t_cmd                  r_cmd;
    logic [UNIQUE_W-1:0]   r_unique;
    logic [UNIQUE_W-1:0]   n_unique;
    logic [63:0]           r_total;
    logic [63:0]           n_total;

    logic                  r_out_valid;
    logic                  r_out_accepted;
    logic                  r_out_new;
    logic [15:0]           r_out_slot;
    logic [COUNT_W-1:0]    r_out_value;
    logic [UNIQUE_W-1:0]   r_out_unique;
    logic [63:0]           r_out_total;

    logic                  out_free;
    logic                  out_load;
    logic                  n_out_accepted;
    logic                  n_out_new;
    logic [15:0]           n_out_slot;
    logic [COUNT_W-1:0]    n_out_value;
    logic [UNIQUE_W-1:0]   n_out_unique;
    logic [63:0]           n_out_total;

    logic                  sweep_last;
    logic                  take_cmd;
    logic                  fresh;

    logic                   edge_we;
    logic [EDGE_MAP_AW-1:0] edge_waddr;
    logic [COUNT_W-1:0]     edge_wdata;
    logic [EDGE_MAP_AW-1:0] edge_raddr;
    logic [COUNT_W-1:0]     edge_rdata;
    logic                   path_we;
    logic [PATH_MAP_AW-1:0] path_waddr;
    logic [COUNT_W-1:0]     path_wdata;
    logic [PATH_MAP_AW-1:0] path_raddr;
    logic [COUNT_W-1:0]     path_rdata;

    ect_ram #(.WIDTH(COUNT_W), .DEPTH(EDGE_MAP_ENTRIES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    ect_ram #(.WIDTH(COUNT_W), .DEPTH(PATH_MAP_ENTRIES)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (path_wdata),
        .i_raddr (path_raddr),
        .o_rdata (path_rdata)
    );

    assign out_free   = !r_out_valid || i_pop;
    assign sweep_last = (r_sweep == SWEEP_AW'(SWEEP_ENTRIES - 1));
    assign take_cmd   = (r_state == S_IDLE) && i_head.valid && out_free;
    assign o_hold     = (r_state == S_INIT);

    // next state
    always_comb begin
        n_state = r_state;
        n_sweep = '0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                n_sweep = r_sweep + SWEEP_AW'(1);
                if (sweep_last) begin
                    n_state = S_IDLE;
                    n_sweep = '0;
                end
            end
            S_IDLE: begin
                if (take_cmd) begin
                    case (i_head.cmd.kind)
                        K_TRACE, K_READ: n_state = S_ACCESS;
                        K_CLEAR:         n_state = S_CLEAR;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_ACCESS: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_q_pop        = 1'b0;
        edge_we        = 1'b0;
        edge_waddr     = r_cmd.edge_idx;
        edge_wdata     = (edge_rdata == COUNTER_MAX) ? edge_rdata : edge_rdata + 8'd1;
        edge_raddr     = i_head.cmd.edge_idx;
        path_we        = 1'b0;
        path_waddr     = r_cmd.path_idx;
        path_wdata     = (path_rdata == COUNTER_MAX) ? path_rdata : path_rdata + 8'd1;
        path_raddr     = i_head.cmd.path_idx;
        fresh          = (edge_rdata == '0);
        n_unique       = r_unique;
        n_total        = r_total;
        out_load       = 1'b0;
        n_out_accepted = 1'b0;
        n_out_new      = 1'b0;
        n_out_slot     = '0;
        n_out_value    = '0;
        n_out_unique   = r_unique;
        n_out_total    = r_total;
        case (r_state)
            S_INIT, S_CLEAR: begin
                edge_we    = (32'(r_sweep) < 32'(EDGE_MAP_ENTRIES));
                edge_waddr = EDGE_MAP_AW'(r_sweep);
                edge_wdata = '0;
                path_we    = (32'(r_sweep) < 32'(PATH_MAP_ENTRIES));
                path_waddr = PATH_MAP_AW'(r_sweep);
                path_wdata = '0;
            end
            S_IDLE: begin
                if (take_cmd) begin
                    o_q_pop = 1'b1;
                    case (i_head.cmd.kind)
                        K_CLEAR: begin
                            out_load     = 1'b1;
                            n_unique     = '0;
                            n_total      = '0;
                            n_out_unique = '0;
                            n_out_total  = '0;
                        end
                        K_DROP: begin
                            out_load = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_ACCESS: begin
                out_load   = 1'b1;
                n_out_slot = r_cmd.slot;
                if (r_cmd.kind == K_TRACE) begin
                    edge_we = 1'b1;
                    path_we = r_cmd.path_upd;
                    if (fresh && (r_unique != UNIQUE_MAX)) begin
                        n_unique = r_unique + 17'd1;
                    end
                    n_total        = r_total + 64'd1;
                    n_out_accepted = 1'b1;
                    n_out_new      = fresh;
                    n_out_value    = edge_wdata;
                    n_out_unique   = n_unique;
                    n_out_total    = n_total;
                end else begin
                    n_out_value = r_cmd.rd_ok ? edge_rdata : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_unique    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_unique <= n_unique;
            r_total  <= n_total;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_head.cmd;
        end
        if (out_load) begin
            r_out_accepted <= n_out_accepted;
            r_out_new      <= n_out_new;
            r_out_slot     <= n_out_slot;
            r_out_value    <= n_out_value;
            r_out_unique   <= n_out_unique;
            r_out_total    <= n_out_total;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_accepted       = r_out_accepted;
    assign o_new_edge       = r_out_new;
    assign o_edge_slot      = r_out_slot;
    assign o_counter_value  = r_out_value;
    assign o_distinct_edges = r_out_unique;
    assign o_edge_total     = r_out_total;

`ifndef SYNTH
    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

    // counts stay zero while a sweep is clearing the maps
    a_sweep_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT || r_state == S_CLEAR) |-> (r_unique == '0 && r_total == '0))
        else $error("counts nonzero during clear sweep");

    // map writes happen only in a sweep or in the update cycle
    a_map_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (edge_we || path_we) |-> (r_state != S_IDLE))
        else $error("map write while idle");

    // the update state is always followed directly by idle
    a_access_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCESS) |=> (r_state == S_IDLE))
        else $error("access state held");
`endif

endmodule

// ===== sv/edge_coverage_tracker.sv =====
// ----------------------------------------------------------------------------
// edge_coverage_tracker
// Branch-edge coverage map with saturating counters, optional path-hash map,
// address window and clear/read operations.
//
//   channel   handshake          payload
//   input     push / full        i_operation, i_program_counter, i_map_index
//   result    empty / pop        o_accepted, o_new_edge, o_edge_slot,
//                                o_counter_value, o_distinct_edges, o_edge_total
//   config    i_cfg_we           i_cfg_index, i_cfg_data
//
// trace and read items pass the back end as a map read, then an update, since
// the map read is registered; dropped items are done when taken from the queue.
// clear runs a sweep of the larger map, one entry a cycle.
// after reset the same sweep runs with full held high.
// a 2-entry command queue lets the front keep taking items while the back or
// the result register is stalled.
// ----------------------------------------------------------------------------
module edge_coverage_tracker import ect_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_program_counter,
    input  logic [15:0] i_map_index,
    output logic        empty,
    input  logic        pop,
    output logic        o_accepted,
    output logic        o_new_edge,
    output logic [15:0] o_edge_slot,
    output logic [7:0]  o_counter_value,
    output logic [16:0] o_distinct_edges,
    output logic [63:0] o_edge_total
);

    logic    q_push;
    t_cmd    q_cmd;
    logic    q_full;
    logic    q_pop;
    t_q_head q_head;
    logic    hold;

    ect_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .i_operation       (i_operation),
        .i_program_counter (i_program_counter),
        .i_map_index       (i_map_index),
        .i_q_full          (q_full),
        .i_hold            (hold),
        .o_full            (full),
        .o_q_push          (q_push),
        .o_q_cmd           (q_cmd)
    );

    ect_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    ect_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (q_head),
        .o_q_pop          (q_pop),
        .o_hold           (hold),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_accepted       (o_accepted),
        .o_new_edge       (o_new_edge),
        .o_edge_slot      (o_edge_slot),
        .o_counter_value  (o_counter_value),
        .o_distinct_edges (o_distinct_edges),
        .o_edge_total     (o_edge_total)
    );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge coverage tracker. A queue-fed driver offers
// trace, clear, read and unused-code operations under several window and
// enable settings. A clocked monitor compares every result transfer field by
// field against an in-bench coverage map predictor. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import ect_pkg::*;

    typedef struct packed {
        t_op         op;
        logic [63:0] pc;
        logic [15:0] idx;
    } t_coverage_op;

    typedef struct packed {
        logic        accepted;
        logic        new_edge;
        logic [15:0] slot;
        logic [7:0]  count;
        logic [16:0] unique_n;
        logic [63:0] total;
    } t_coverage_report;

    localparam logic [63:0] LOOP_PC = 64'h0000_0000_0040_1a3c;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_operation = '0;
    logic [63:0] i_program_counter = '0;
    logic [15:0] i_map_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_accepted;
    logic        o_new_edge;
    logic [15:0] o_edge_slot;
    logic [7:0]  o_counter_value;
    logic [16:0] o_distinct_edges;
    logic [63:0] o_edge_total;

    edge_coverage_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_operation      (i_operation),
        .i_program_counter(i_program_counter),
        .i_map_index      (i_map_index),
        .empty            (empty),
        .pop              (pop),
        .o_accepted       (o_accepted),
        .o_new_edge       (o_new_edge),
        .o_edge_slot      (o_edge_slot),
        .o_counter_value  (o_counter_value),
        .o_distinct_edges (o_distinct_edges),
        .o_edge_total     (o_edge_total)
    );

    always #6 i_clk = ~i_clk;

    // predictor state and its copy of the registers
    logic [7:0]       edge_hits [EDGE_MAP_ENTRIES];
    logic [63:0]      last_loc = '0;
    logic [16:0]      unique_hits = '0;
    logic [63:0]      total_hits = '0;
    logic             cfg_trace_on = 1'b0;
    logic [63:0]      cfg_win_lo = '0;
    logic [63:0]      cfg_win_hi = '0;

    t_coverage_op     pending_ops [$];
    t_coverage_report expected_reports [$];
    t_coverage_op     offered_op;
    t_coverage_report report_want;
    int               mismatches = 0;
    int               send_idle = 0;
    int               recv_idle = 0;
    int               hold_left = 0;
    int               holds_done = 0;
    int               reports_seen = 0;
    bit               quiet_tail = 1'b0;

    function automatic void wipe_coverage();
        foreach (edge_hits[i]) edge_hits[i] = '0;
        last_loc    = '0;
        unique_hits = '0;
        total_hits  = '0;
    endfunction

    // the path map never reaches the outputs, so only the edge map is kept
    function automatic t_coverage_report predict_coverage(t_coverage_op item);
        t_coverage_report r;
        logic [63:0]      loc;
        logic [15:0]      slot;
        logic [7:0]       old;
        r = '0;
        if (item.op == OP_TRACE && cfg_trace_on &&
            (cfg_win_lo == 0 || cfg_win_hi == 0 ||
             (item.pc >= cfg_win_lo && item.pc <= cfg_win_hi))) begin
            loc = item.pc;
            if (cfg_win_lo != 0 && item.pc >= cfg_win_lo)
                loc = item.pc - cfg_win_lo;
            slot = 16'((last_loc >> 1) ^ loc);
            old  = edge_hits[slot];
            if (old != COUNTER_MAX)
                edge_hits[slot] = old + 8'd1;
            if (old == 0) begin
                r.new_edge = 1'b1;
                if (unique_hits != UNIQUE_MAX)
                    unique_hits = unique_hits + 17'd1;
            end
            total_hits = total_hits + 64'd1;
            last_loc   = loc;
            r.accepted = 1'b1;
            r.slot     = slot;
            r.count    = edge_hits[slot];
        end else if (item.op == OP_CLEAR) begin
            wipe_coverage();
        end else if (item.op == OP_READ) begin
            r.slot  = item.idx;
            r.count = edge_hits[item.idx];
        end
        r.unique_n = unique_hits;
        r.total    = total_hits;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                expected_reports.push_back(predict_coverage(offered_op));
            if (!push || !full) begin
                if (send_idle > 0) begin
                    send_idle--;
                    push <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    send_idle = $urandom_range(0, 2);
                    push <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    offered_op = pending_ops.pop_front();
                    i_operation       <= offered_op.op;
                    i_program_counter <= offered_op.pc;
                    i_map_index       <= offered_op.idx;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t unexpected result transfer: expected none, actual slot %0h",
                             $time, o_edge_slot);
                    mismatches++;
                end else begin
                    report_want = expected_reports.pop_front();
                    check_field("accepted", 64'(report_want.accepted), 64'(o_accepted));
                    check_field("new_edge", 64'(report_want.new_edge), 64'(o_new_edge));
                    check_field("edge_slot", 64'(report_want.slot), 64'(o_edge_slot));
                    check_field("counter_value", 64'(report_want.count),
                                64'(o_counter_value));
                    check_field("distinct_edges", 64'(report_want.unique_n),
                                64'(o_distinct_edges));
                    check_field("edge_total", report_want.total, o_edge_total);
                end
                reports_seen++;
            end
            // long hold-offs so the input side backs up and full rises
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (holds_done < 2 && reports_seen >= 400 + 600 * holds_done) begin
                hold_left = 80;
                holds_done++;
                pop <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle--;
                pop <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                recv_idle = $urandom_range(0, 2);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic queue_op(input t_op op, input logic [63:0] pc, input logic [15:0] idx);
        t_coverage_op item;
        item.op  = op;
        item.pc  = pc;
        item.idx = idx;
        pending_ops.push_back(item);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || push || expected_reports.size() != 0 || full);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TRACE_EN:  cfg_trace_on = value[0];
            CFG_WIN_START: cfg_win_lo = value;
            CFG_WIN_END:   cfg_win_hi = value;
            default: begin
            end
        endcase
    endtask

    task automatic apply_config(input logic trace_on, input logic path_on,
                                input logic [63:0] win_lo, input logic [63:0] win_hi);
        wait_drained();
        write_reg(CFG_TRACE_EN, {63'd0, trace_on});
        write_reg(CFG_PATH_EN, {63'd0, path_on});
        write_reg(CFG_WIN_START, win_lo);
        write_reg(CFG_WIN_END, win_hi);
    endtask

    task automatic run_random_phase(input int n_items, input bit allow_clear);
        logic [63:0] ws;
        logic [63:0] we;
        logic [63:0] base;
        logic [63:0] hot_pc [8];
        logic [63:0] hot_loc [8];
        int          span;
        int          mode;
        int          clear_at;
        int          pick;
        int          a;
        int          b;
        logic        te;
        te   = ($urandom_range(0, 7) != 0);
        mode = $urandom_range(0, 4);
        span = $urandom_range(63, 4095);
        ws   = '0;
        we   = '0;
        base = {$urandom, $urandom};
        case (mode)
            0: begin
            end
            1: begin
                // start only: normalization below and above the start
                ws   = base;
                base = ws - 64'd2048;
            end
            2: begin
                we = base + span;
            end
            3: begin
                ws = base;
                we = base + span;
            end
            default: begin
                ws   = $urandom_range(1, 1 << 20);
                we   = ws + span;
                base = ws;
            end
        endcase
        for (int k = 0; k < 8; k++) begin
            hot_pc[k]  = base + $urandom_range(0, span);
            hot_loc[k] = (ws != 0 && hot_pc[k] >= ws) ? hot_pc[k] - ws : hot_pc[k];
        end
        apply_config(te, 1'($urandom_range(0, 1)), ws, we);
        clear_at = (allow_clear && $urandom_range(0, 1) == 1) ?
                   $urandom_range(0, n_items - 1) : -1;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            a    = $urandom_range(0, 7);
            b    = $urandom_range(0, 7);
            if (i == clear_at)
                queue_op(OP_CLEAR, {$urandom, $urandom}, 16'($urandom));
            else if (pick < 55)
                queue_op(OP_TRACE, hot_pc[a], 16'($urandom));
            else if (pick < 75)
                queue_op(OP_TRACE, base + $urandom_range(0, span), 16'($urandom));
            else if (pick < 82)
                queue_op(OP_TRACE, {$urandom, $urandom}, 16'($urandom));
            else if (pick < 95)
                queue_op(OP_READ, {$urandom, $urandom},
                         ($urandom_range(0, 1) == 1) ?
                         16'((hot_loc[a] >> 1) ^ hot_loc[b]) : 16'($urandom));
            else
                queue_op(OP_UNUSED, {$urandom, $urandom}, 16'($urandom));
        end
    endtask

    initial begin
        wipe_coverage();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: tracing off, window unset
        queue_op(OP_TRACE, '1, 16'h0000);
        queue_op(OP_READ, '0, 16'h0000);
        queue_op(OP_READ, '0, 16'hffff);
        queue_op(OP_UNUSED, '0, 16'hffff);

        apply_config(1'b1, 1'b1, '0, '0);
        queue_op(OP_TRACE, '0, 16'h0000);
        queue_op(OP_TRACE, '0, 16'h0000);
        queue_op(OP_TRACE, '1, 16'hffff);
        queue_op(OP_TRACE, 64'h5555_5555_5555_5555, 16'h5555);
        queue_op(OP_READ, '0, 16'h0000);
        queue_op(OP_READ, '1, 16'hffff);
        queue_op(OP_UNUSED, '1, 16'haaaa);
        queue_op(OP_CLEAR, '1, 16'hffff);
        queue_op(OP_TRACE, 64'h8000_0000_0000_0001, 16'h0000);
        queue_op(OP_READ, '0, 16'h0000);

        // bounded window: below, lower bound, upper bound, above, inside
        apply_config(1'b1, 1'b0, 64'h1000, 64'h1_ffff);
        queue_op(OP_TRACE, 64'h0fff, 16'h0000);
        queue_op(OP_TRACE, 64'h1000, 16'h0000);
        queue_op(OP_TRACE, 64'h1_ffff, 16'h0000);
        queue_op(OP_TRACE, 64'h2_0000, 16'h0000);
        queue_op(OP_TRACE, 64'h1800, 16'h0000);

        // end unset: everything passes, only addresses above the start shift
        apply_config(1'b1, 1'b0, 64'h8000_0000_0000_0000, '0);
        queue_op(OP_TRACE, 64'h10, 16'h0000);
        queue_op(OP_TRACE, 64'h8000_0000_0000_0010, 16'h0000);
        queue_op(OP_TRACE, '1, 16'h0000);

        apply_config(1'b1, 1'b1, '1, '1);
        queue_op(OP_TRACE, '1, 16'h0000);
        queue_op(OP_TRACE, '0, 16'h0000);

        // start unset with end at the top
        apply_config(1'b1, 1'b0, '0, '1);
        queue_op(OP_TRACE, 64'h1234, 16'h0000);

        // tight loop drives one counter into saturation
        apply_config(1'b1, 1'b1, '0, '0);
        for (int i = 0; i < 270; i++)
            queue_op(OP_TRACE, LOOP_PC, 16'($urandom));
        queue_op(OP_READ, '0, 16'((LOOP_PC >> 1) ^ LOOP_PC));
        queue_op(OP_READ, '1, 16'((LOOP_PC >> 1) ^ LOOP_PC));

        for (int p = 0; p < 4; p++)
            run_random_phase(250, 1'b1);
        wait_drained();
        quiet_tail = 1'b1;
        run_random_phase(250, 1'b1);
        wait_drained();

        if (mismatches == 0)
            $display("PASS edge_coverage_tracker");
        else
            $display("FAIL edge_coverage_tracker");
        $finish;
    end

    initial begin
        #48000000;
        $display("FAIL edge_coverage_tracker");
        $finish;
    end

endmodule
